FILE: rtl/hafe_pkg.sv
`timescale 1ns / 1ps

package hafe_pkg;

    localparam int QDEPTH = 4;
    localparam int QPTR_W = $clog2(QDEPTH);
    localparam int QCNT_W = $clog2(QDEPTH + 1);

    localparam logic [7:0] CHAR_COLON = 8'h3A;
    localparam logic [7:0] CHAR_CR    = 8'h0D;
    localparam logic [7:0] CHAR_LF    = 8'h0A;

    localparam logic [3:0] HDR_LAST_POS  = 4'd8;
    localparam logic [3:0] DATA_LAST_POS = 4'd1;
    localparam logic [3:0] HDR_BODY_LEN  = 4'd9;
    localparam logic [3:0] DATA_BODY_LEN = 4'd2;
    localparam logic [3:0] TAIL_LEN      = 4'd4;

    typedef enum logic [1:0] {
        TAIL_CHK_HI = 2'd0,
        TAIL_CHK_LO = 2'd1,
        TAIL_CR     = 2'd2,
        TAIL_LF     = 2'd3
    } tail_pos_t;

    // One queued command: a header or a data byte, with the checksum tail flag.
    typedef struct packed {
        logic       is_header;
        logic       tail;
        logic [7:0] b0;
        logic [7:0] b1;
        logic [7:0] b2;
        logic [7:0] b3;
        logic [7:0] chk;
    } cmd_t;

    typedef struct packed {
        logic empty;
        logic full;
    } qstat_t;

    function automatic logic [7:0] hex_char(input logic [3:0] nib);
        logic [7:0] wide;
        wide = {4'd0, nib};
        return (nib < 4'd10) ? (8'h30 + wide) : (8'h37 + wide);
    endfunction

endpackage

FILE: rtl/hex_ascii_frame_encoder.sv
`timescale 1ns / 1ps
// Channel  Handshake                 Payload
// item     item_valid / item_ready   func, data_length, sign_address, msg_type, data_byte
// char     char_valid / char_ready   out_char, run_last, frame_end
//
// The output register sends one character per cycle while char_ready is high: a header
// is 9 characters, 13 for an empty frame, and a data byte 2, or 6 if it ends the frame.
// A data request outside an open frame is accepted and sends nothing.
// A four-entry command queue lets requests enter while characters wait on char_ready.
// Reset closes any frame, clears the checksum and empties the queue and the output.

module hex_ascii_frame_encoder
    import hafe_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        item_valid,
    output logic        item_ready,
    input  logic        func,
    input  logic [7:0]  data_length,
    input  logic [15:0] sign_address,
    input  logic [7:0]  msg_type,
    input  logic [7:0]  data_byte,
    output logic        char_valid,
    input  logic        char_ready,
    output logic [7:0]  out_char,
    output logic        run_last,
    output logic        frame_end
);

    qstat_t qstat;
    cmd_t   wr_cmd, head;
    logic   push, pop;

    hafe_front u_front (
        .clk          (clk),
        .rst_n        (rst_n),
        .item_valid   (item_valid),
        .item_ready   (item_ready),
        .func         (func),
        .data_length  (data_length),
        .sign_address (sign_address),
        .msg_type     (msg_type),
        .data_byte    (data_byte),
        .qstat        (qstat),
        .push         (push),
        .cmd          (wr_cmd)
    );

    hafe_queue u_queue (
        .clk    (clk),
        .rst_n  (rst_n),
        .push   (push),
        .wr_cmd (wr_cmd),
        .pop    (pop),
        .rd_cmd (head),
        .qstat  (qstat)
    );

    hafe_back u_back (
        .clk        (clk),
        .rst_n      (rst_n),
        .head       (head),
        .qstat      (qstat),
        .pop        (pop),
        .char_valid (char_valid),
        .char_ready (char_ready),
        .out_char   (out_char),
        .run_last   (run_last),
        .frame_end  (frame_end)
    );

    a_end_is_last_lf: assert property (@(posedge clk) disable iff (!rst_n)
        char_valid && frame_end |-> run_last && (out_char == CHAR_LF))
        else $error("frame end not on the last LF of a request");

    a_queue_flags: assert property (@(posedge clk) disable iff (!rst_n)
        !(qstat.empty && qstat.full))
        else $error("queue both empty and full");

    a_no_pop_empty: assert property (@(posedge clk) disable iff (!rst_n)
        pop |-> !qstat.empty)
        else $error("queue popped while empty");

    a_full_stalls: assert property (@(posedge clk) disable iff (!rst_n)
        qstat.full && !pop |=> !qstat.empty)
        else $error("full queue lost entries");

endmodule

FILE: rtl/hafe_front.sv
`timescale 1ns / 1ps

module hafe_front
    import hafe_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        item_valid,
    output logic        item_ready,
    input  logic        func,
    input  logic [7:0]  data_length,
    input  logic [15:0] sign_address,
    input  logic [7:0]  msg_type,
    input  logic [7:0]  data_byte,
    input  qstat_t      qstat,
    output logic        push,
    output cmd_t        cmd
);

    logic       frame_open_reg, frame_open_next;
    logic [7:0] remaining_reg, remaining_next;
    logic [7:0] chk_reg, chk_next;
    logic       accept;
    logic [7:0] rem_dec;

    assign item_ready = !qstat.full;
    assign accept     = item_valid && item_ready;
    assign rem_dec    = remaining_reg - 8'd1;

    always_comb
    begin
        frame_open_next = frame_open_reg;
        remaining_next  = remaining_reg;
        chk_next        = chk_reg;
        push            = 1'b0;
        cmd.is_header   = !func;
        cmd.b0          = data_length;
        cmd.b1          = sign_address[15:8];
        cmd.b2          = sign_address[7:0];
        cmd.b3          = msg_type;
        cmd.tail        = 1'b0;
        if (!func)
        begin
            chk_next = 8'd0 - data_length - sign_address[15:8] - sign_address[7:0] - msg_type;
            cmd.tail = (data_length == 8'd0);
            if (accept)
            begin
                push            = 1'b1;
                frame_open_next = (data_length != 8'd0);
                remaining_next  = data_length;
            end
        end
        else
        begin
            cmd.b0   = data_byte;
            chk_next = chk_reg - data_byte;
            cmd.tail = (rem_dec == 8'd0);
            if (accept && frame_open_reg)
            begin
                push            = 1'b1;
                frame_open_next = (rem_dec != 8'd0);
                remaining_next  = rem_dec;
            end
        end
        cmd.chk = chk_next;
        if (!push)
        begin
            chk_next = chk_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            frame_open_reg <= 1'b0;
            remaining_reg  <= 8'd0;
            chk_reg        <= 8'd0;
        end
        else
        begin
            frame_open_reg <= frame_open_next;
            remaining_reg  <= remaining_next;
            chk_reg        <= chk_next;
        end
    end

endmodule

FILE: rtl/hafe_queue.sv
`timescale 1ns / 1ps

module hafe_queue
    import hafe_pkg::*;
(
    input  logic   clk,
    input  logic   rst_n,
    input  logic   push,
    input  cmd_t   wr_cmd,
    input  logic   pop,
    output cmd_t   rd_cmd,
    output qstat_t qstat
);

    cmd_t              slots [QDEPTH];
    logic [QPTR_W-1:0] wr_ptr_reg, rd_ptr_reg;
    logic [QCNT_W-1:0] count_reg, count_next;

    assign qstat.empty = (count_reg == QCNT_W'(0));
    assign qstat.full  = (count_reg == QCNT_W'(QDEPTH));
    assign rd_cmd      = slots[rd_ptr_reg];

    always_comb
    begin
        count_next = count_reg;
        if (push && !pop)
        begin
            count_next = count_reg + QCNT_W'(1);
        end
        else if (pop && !push)
        begin
            count_next = count_reg - QCNT_W'(1);
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            slots[wr_ptr_reg] <= wr_cmd;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            if (push)
            begin
                wr_ptr_reg <= wr_ptr_reg + QPTR_W'(1);
            end
            if (pop)
            begin
                rd_ptr_reg <= rd_ptr_reg + QPTR_W'(1);
            end
            count_reg <= count_next;
        end
    end

endmodule

FILE: rtl/hafe_back.sv
`timescale 1ns / 1ps

module hafe_back
    import hafe_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    input  cmd_t       head,
    input  qstat_t     qstat,
    output logic       pop,
    output logic       char_valid,
    input  logic       char_ready,
    output logic [7:0] out_char,
    output logic       run_last,
    output logic       frame_end
);

    logic       valid_reg, valid_next;
    logic [7:0] char_reg;
    logic       last_reg;
    logic       end_reg;
    logic [3:0] pos_reg;
    logic       load, emit, is_last, is_end;
    logic [3:0] last_pos, body_len, tail_off;
    logic [7:0] ch;

    assign load     = !valid_reg || char_ready;
    assign emit     = load && !qstat.empty;
    assign body_len = head.is_header ? HDR_BODY_LEN : DATA_BODY_LEN;
    assign last_pos = (head.is_header ? HDR_LAST_POS : DATA_LAST_POS)
                      + (head.tail ? TAIL_LEN : 4'd0);
    assign tail_off = pos_reg - body_len;
    assign is_last  = (pos_reg == last_pos);
    assign pop      = emit && is_last;

    always_comb
    begin
        ch     = CHAR_CR;
        is_end = 1'b0;
        if (pos_reg < body_len)
        begin
            if (head.is_header)
            begin
                unique case (pos_reg)
                    4'd0:    ch = CHAR_COLON;
                    4'd1:    ch = hex_char(head.b0[7:4]);
                    4'd2:    ch = hex_char(head.b0[3:0]);
                    4'd3:    ch = hex_char(head.b1[7:4]);
                    4'd4:    ch = hex_char(head.b1[3:0]);
                    4'd5:    ch = hex_char(head.b2[7:4]);
                    4'd6:    ch = hex_char(head.b2[3:0]);
                    4'd7:    ch = hex_char(head.b3[7:4]);
                    default: ch = hex_char(head.b3[3:0]);
                endcase
            end
            else
            begin
                ch = (pos_reg == 4'd0) ? hex_char(head.b0[7:4]) : hex_char(head.b0[3:0]);
            end
        end
        else
        begin
            unique case (tail_pos_t'(tail_off[1:0]))
                TAIL_CHK_HI: ch = hex_char(head.chk[7:4]);
                TAIL_CHK_LO: ch = hex_char(head.chk[3:0]);
                TAIL_CR:     ch = CHAR_CR;
                TAIL_LF:
                begin
                    ch     = CHAR_LF;
                    is_end = 1'b1;
                end
                default:     ch = CHAR_CR;
            endcase
        end
    end

    always_comb
    begin
        valid_next = valid_reg;
        if (emit)
        begin
            valid_next = 1'b1;
        end
        else if (char_ready)
        begin
            valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (emit)
        begin
            char_reg <= ch;
            last_reg <= is_last;
            end_reg  <= is_end;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
            pos_reg   <= 4'd0;
        end
        else
        begin
            valid_reg <= valid_next;
            if (emit)
            begin
                pos_reg <= is_last ? 4'd0 : pos_reg + 4'd1;
            end
        end
    end

    assign char_valid = valid_reg;
    assign out_char   = char_reg;
    assign run_last   = last_reg;
    assign frame_end  = end_reg;

endmodule
